// ===== src/mavgs_pkg.sv =====
// Package for the moving-average early-stop block: field widths, register indexes,
// payload structs and the shared ALU operation codes.
// No dependencies; every other file of the block imports it.
`default_nettype none

package mavgs_pkg;

   localparam int SCORE_W            = 32;
   localparam int TOL_W              = 16;
   localparam int JUMP_W             = 16;
   localparam int DIV_STEPS          = 16;
   localparam int WINDOW_LEN_DEFAULT = 3;
   localparam int CSR_IDX_W          = 1;
   localparam int CSR_DATA_W         = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOLERANCE      = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MORE_IS_BETTER = 1'd1;

   typedef enum logic {
      ALU_ADD = 1'b0,
      ALU_SUB = 1'b1
   } alu_op_type;

   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic               new_series;
   } req_type;

   typedef struct packed {
      logic                     stop;
      logic                     history_full;
      logic signed [JUMP_W-1:0] jump;
   } rsp_type;

endpackage

`default_nettype wire

// ===== src/mavgs_hist.sv =====
// Score history of the early-stop block: circular buffer of the last 2K scores,
// write pointer and saturating count of scores seen. Depends on mavgs_pkg.
`default_nettype none

module mavgs_hist #(
   parameter int WINDOW_LEN = mavgs_pkg::WINDOW_LEN_DEFAULT,
   localparam int DEPTH     = 2 * WINDOW_LEN,
   localparam int PTR_W     = $clog2(DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         wr_en,
   input  wire logic                         wr_fresh,
   input  wire logic [mavgs_pkg::SCORE_W-1:0] wr_data,
   input  wire logic [PTR_W-1:0]             rd_addr,
   output logic      [mavgs_pkg::SCORE_W-1:0] rd_data,
   output logic      [PTR_W-1:0]             wr_ptr_next,
   output logic                              full_next
);
   import mavgs_pkg::*;

   localparam int FULL  = DEPTH + 1;
   localparam int CNT_W = $clog2(FULL + 1);

   logic [SCORE_W-1:0] hist_ff [DEPTH];
   logic [PTR_W-1:0]   wp_ff, wp_in, base;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, cnt_base, cnt_new;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   always_comb begin
      base     = wr_fresh ? '0 : wp_ff;
      cnt_base = wr_fresh ? '0 : cnt_ff;
      cnt_new  = (cnt_base < CNT_W'(FULL)) ? cnt_base + 1'b1 : cnt_base;
      // After the write the pointer addresses the oldest score of the history.
      wr_ptr_next = ptr_inc(base);
      full_next   = (cnt_new == CNT_W'(FULL));
      wp_in  = wp_ff;
      cnt_in = cnt_ff;
      if (wr_en) begin
         wp_in  = wr_ptr_next;
         cnt_in = cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hist_ff[base] <= wr_data;
      end
   end

   assign rd_data = hist_ff[rd_addr];

endmodule

`default_nettype wire

// ===== src/mavgs_alu.sv =====
// Shared add/subtract unit of the early-stop block, used for window sums,
// tolerance compares and the restoring divider. Depends on mavgs_pkg.
`default_nettype none

module mavgs_alu #(
   parameter int W = 56
) (
   input  wire logic                  [W-1:0] a,
   input  wire logic                  [W-1:0] b,
   input  wire mavgs_pkg::alu_op_type         op,
   output logic                       [W-1:0] res,
   output logic                               borrow
);
   import mavgs_pkg::*;

   logic [W:0] full;

   always_comb begin
      unique case (op)
         ALU_ADD: full = {1'b0, a} + {1'b0, b};
         ALU_SUB: full = {1'b0, a} - {1'b0, b};
         default: full = '0;
      endcase
   end

   assign res = full[W-1:0];
   // On a subtract the top bit is set exactly when a < b.
   assign borrow = (op == ALU_SUB) && full[W];

endmodule

`default_nettype wire

// ===== src/moving_average_early_stop.sv =====
// Moving-average early-stop detector, top level. Uses mavgs_pkg, mavgs_hist, mavgs_alu.
// Each request carries one score (unsigned Q16.16) and a new-series flag. The block
// appends the score to a history of the last 2K scores (K = WINDOW_LEN) and returns
// exactly one response: stop, history_full and jump (signed Q1.15). Until 2K+1 scores
// of the current series are seen, the response is all zero.
// Both channels use valid/stall; req_stall is high whenever the sequencer is busy.
// A request that does not fill the history goes from the idle state straight to
// the output state. Otherwise a shared adder walks the windows: the first window sum,
// a multiply step for the tolerance bound, an add, subtract and compare per later
// window, a difference, absolute value and denominator step to form the jump operands
// and 16 divider steps; the next request is taken once the sequencer is back in idle.
// The response sits in an output register; a new request is taken while it waits,
// and the next result is held in the sequencer until the receiver drops rsp_stall.
// Configuration writes (tolerance, more_is_better) are taken at any time through the
// csr port and should only be made while the block is idle.
// Synchronous reset clears the history count and pointer, the sequencer state, the
// configuration registers and the response valid flag; the score storage itself is
// not cleared.
`default_nettype none

module moving_average_early_stop #(
   parameter int WINDOW_LEN = mavgs_pkg::WINDOW_LEN_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire mavgs_pkg::req_type                req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output mavgs_pkg::rsp_type                     rsp_data,
   input  wire logic                              csr_wr_en,
   input  wire logic [mavgs_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [mavgs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import mavgs_pkg::*;

   localparam int DEPTH  = 2 * WINDOW_LEN;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SUM_W  = SCORE_W + $clog2(WINDOW_LEN);
   localparam int FAC_W  = TOL_W + 1;
   localparam int CMP_W  = SUM_W + FAC_W;
   localparam int DEN_W  = SUM_W + 1;
   localparam int REM_W  = SUM_W + 2;
   localparam int STEP_W = ($clog2(WINDOW_LEN) > $clog2(DIV_STEPS)) ?
                           $clog2(WINDOW_LEN) : $clog2(DIV_STEPS);

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_SUM  = 11'b000_0000_0010,
      ST_MULT = 11'b000_0000_0100,
      ST_ADD  = 11'b000_0000_1000,
      ST_SUB  = 11'b000_0001_0000,
      ST_CMP  = 11'b000_0010_0000,
      ST_DIFF = 11'b000_0100_0000,
      ST_ABS  = 11'b000_1000_0000,
      ST_DEN  = 11'b001_0000_0000,
      ST_DIV  = 11'b010_0000_0000,
      ST_OUT  = 11'b100_0000_0000
   } state_type;

   state_type           state_ff, state_in;
   logic [TOL_W-1:0]    tol_ff, tol_in;
   logic                mib_ff, mib_in;
   logic [SUM_W-1:0]    acc_ff, acc_in;
   logic [SUM_W-1:0]    s0_ff, s0_in;
   logic [CMP_W-1:0]    rhs_ff, rhs_in;
   logic                improved_ff, improved_in;
   logic                neg_ff, neg_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]    den_ff, den_in;
   logic [JUMP_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PTR_W-1:0]    rd_ff, rd_in;
   logic [PTR_W-1:0]    tl_ff, tl_in;
   rsp_type             res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                req_accept;
   logic [PTR_W-1:0]    hist_rd_addr;
   logic [SCORE_W-1:0]  hist_rd_data;
   logic [PTR_W-1:0]    hist_ptr_next;
   logic                hist_full_next;

   logic [CMP_W-1:0]    alu_a, alu_b, alu_res;
   alu_op_type          alu_op;
   logic                alu_borrow;

   logic [FAC_W-1:0]    factor;
   logic [CMP_W-1:0]    prod;
   logic [CMP_W-1:0]    lhs;
   logic [REM_W-1:0]    div_trial, div_rem;
   logic                div_bit, div_last;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] ptr);
      ptr_inc = (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
   endfunction

   // Quotient magnitude is at most 32768; a positive full-scale result saturates.
   function automatic logic [JUMP_W-1:0] jump_of(input logic [JUMP_W-1:0] q,
                                                 input logic neg, input logic den_zero);
      logic [JUMP_W-1:0] j;
      if (den_zero) begin
         j = '0;
      end else if (neg) begin
         j = ~q + 1'b1;
      end else if (q[JUMP_W-1]) begin
         j = {1'b0, {(JUMP_W-1){1'b1}}};
      end else begin
         j = q;
      end
      jump_of = j;
   endfunction

   assign req_stall  = reset || (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   assign hist_rd_addr = (state_ff == ST_SUB) ? tl_ff : rd_ff;

   mavgs_hist #(
      .WINDOW_LEN(WINDOW_LEN)
   ) u_hist (
      .clock       (clock),
      .reset       (reset),
      .wr_en       (req_accept),
      .wr_fresh    (req_data.new_series),
      .wr_data     (req_data.score),
      .rd_addr     (hist_rd_addr),
      .rd_data     (hist_rd_data),
      .wr_ptr_next (hist_ptr_next),
      .full_next   (hist_full_next)
   );

   mavgs_alu #(
      .W(CMP_W)
   ) u_alu (
      .a      (alu_a),
      .b      (alu_b),
      .op     (alu_op),
      .res    (alu_res),
      .borrow (alu_borrow)
   );

   assign factor = mib_ff ? (FAC_W'(1) << TOL_W) + FAC_W'(tol_ff)
                          : (FAC_W'(1) << TOL_W) - FAC_W'(tol_ff);
   assign prod   = CMP_W'(acc_ff) * CMP_W'(factor);
   assign lhs    = CMP_W'({acc_ff, {TOL_W{1'b0}}});

   assign div_trial = alu_res[REM_W-1:0];
   assign div_bit   = !alu_borrow;
   assign div_rem   = div_bit ? div_trial : rem_ff;
   assign div_last  = (step_ff == STEP_W'(DIV_STEPS - 1));

   // Operand selection for the shared adder.
   always_comb begin
      alu_a  = CMP_W'(acc_ff);
      alu_b  = CMP_W'(hist_rd_data);
      alu_op = ALU_ADD;
      unique case (state_ff)
         ST_SUM, ST_ADD: begin
            alu_op = ALU_ADD;
         end
         ST_SUB: begin
            alu_op = ALU_SUB;
         end
         ST_CMP: begin
            alu_op = ALU_SUB;
            alu_a  = mib_ff ? rhs_ff : lhs;
            alu_b  = mib_ff ? lhs : rhs_ff;
         end
         ST_DIFF: begin
            alu_op = ALU_SUB;
            alu_a  = CMP_W'(s0_ff);
            alu_b  = CMP_W'(acc_ff);
         end
         ST_ABS: begin
            alu_op = ALU_SUB;
            alu_a  = neg_ff ? CMP_W'(acc_ff) : CMP_W'(s0_ff);
            alu_b  = neg_ff ? CMP_W'(s0_ff) : CMP_W'(acc_ff);
         end
         ST_DEN: begin
            alu_op = ALU_ADD;
            alu_a  = CMP_W'(s0_ff);
            alu_b  = CMP_W'(acc_ff);
         end
         ST_DIV: begin
            alu_op = ALU_SUB;
            alu_a  = CMP_W'(rem_ff);
            alu_b  = CMP_W'(den_ff);
         end
         ST_IDLE, ST_MULT, ST_OUT: begin
            alu_op = ALU_ADD;
         end
         default: begin
            alu_op = ALU_ADD;
         end
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      tol_in       = tol_ff;
      mib_in       = mib_ff;
      acc_in       = acc_ff;
      s0_in        = s0_ff;
      rhs_in       = rhs_ff;
      improved_in  = improved_ff;
      neg_in       = neg_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      rd_in        = rd_ff;
      tl_in        = tl_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TOLERANCE:      tol_in = csr_wdata[TOL_W-1:0];
            CSR_MORE_IS_BETTER: mib_in = csr_wdata[0];
            default:            tol_in = tol_ff;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               acc_in      = '0;
               step_in     = '0;
               improved_in = 1'b0;
               rd_in       = hist_ptr_next;
               tl_in       = hist_ptr_next;
               if (hist_full_next) begin
                  state_in = ST_SUM;
               end else begin
                  res_in   = '0;
                  state_in = ST_OUT;
               end
            end
         end
         ST_SUM: begin
            acc_in = alu_res[SUM_W-1:0];
            rd_in  = ptr_inc(rd_ff);
            if (step_ff == STEP_W'(WINDOW_LEN - 1)) begin
               step_in  = '0;
               state_in = ST_MULT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_MULT: begin
            s0_in    = acc_ff;
            rhs_in   = prod;
            state_in = ST_ADD;
         end
         ST_ADD: begin
            acc_in   = alu_res[SUM_W-1:0];
            rd_in    = ptr_inc(rd_ff);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            acc_in   = alu_res[SUM_W-1:0];
            tl_in    = ptr_inc(tl_ff);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // A borrow here means the window beat the tolerance bound.
            improved_in = improved_ff || alu_borrow;
            if (step_ff == STEP_W'(WINDOW_LEN - 1)) begin
               step_in  = '0;
               state_in = ST_DIFF;
            end else begin
               step_in  = step_ff + 1'b1;
               state_in = ST_ADD;
            end
         end
         ST_DIFF: begin
            neg_in   = alu_borrow;
            state_in = ST_ABS;
         end
         ST_ABS: begin
            rem_in   = alu_res[REM_W-1:0];
            state_in = ST_DEN;
         end
         ST_DEN: begin
            den_in   = alu_res[DEN_W-1:0];
            quo_in   = '0;
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in = {quo_ff[JUMP_W-2:0], div_bit};
            rem_in = div_last ? div_rem : {div_rem[REM_W-2:0], 1'b0};
            if (div_last) begin
               res_in.stop         = !improved_ff;
               res_in.history_full = 1'b1;
               res_in.jump         = jump_of({quo_ff[JUMP_W-2:0], div_bit}, neg_ff,
                                             den_ff == '0);
               state_in = ST_OUT;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         tol_ff       <= '0;
         mib_ff       <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tol_ff       <= tol_in;
         mib_ff       <= mib_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      s0_ff       <= s0_in;
      rhs_ff      <= rhs_in;
      improved_ff <= improved_in;
      neg_ff      <= neg_in;
      rem_ff      <= rem_in;
      den_ff      <= den_in;
      quo_ff      <= quo_in;
      rd_ff       <= rd_in;
      tl_ff       <= tl_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== src/mavgs_check.sv =====
// Port-level assertions for the moving-average early-stop block and the bind
// that attaches them to the top level. Depends on mavgs_pkg.
`default_nettype none

module mavgs_check (
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire mavgs_pkg::rsp_type  rsp_data
);
   import mavgs_pkg::*;

   // A stalled response stays valid and keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // The block is busy in the cycle after it takes a request.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous one is still in work");

   // Before the history fills, the response carries no stop and no jump.
   a_not_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.history_full |-> !rsp_data.stop && (rsp_data.jump == '0))
      else $error("response without full history carries stop or jump");

   // Reset leaves no response pending.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind moving_average_early_stop mavgs_check u_check (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
